// ===== design/rtsa_pkg.sv =====
// shared constants, types and index functions for the reduced tile scatter address block
`timescale 1ns / 1ps
`default_nettype none
package rtsa_pkg;

  localparam int TILE_DIM   = 32;
  localparam int FACE_DIM   = 16;
  localparam int GROUP_W    = 24;
  localparam int DIVISOR_W  = 16;
  localparam int TAG_W      = 12;
  localparam int STEP_BITS  = 2;
  localparam int DIV_STAGES = GROUP_W / STEP_BITS;
  localparam int SRC_W      = 10;
  localparam int DST_W      = 32;
  localparam int COL_W      = 5;
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILES_PER_ROW       = 3'd0,
    REG_FIRST_TILE          = 3'd1,
    REG_OUT_ROWS            = 3'd2,
    REG_OUT_COLS            = 3'd3,
    REG_TILE_ROWS_PER_BATCH = 3'd4,
    REG_TILE_ELEMENTS       = 3'd5,
    REG_REDUCE_ROWS         = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [11:0] tiles_per_row;
    logic [23:0] first_tile;
    logic [15:0] out_rows;
    logic [15:0] out_cols;
    logic [11:0] tile_rows_per_batch;
    logic [12:0] tile_elements;
    logic        reduce_rows;
  } rtsa_cfg_t;

  typedef struct packed {
    logic [GROUP_W-1:0]   num;
    logic [DIVISOR_W-1:0] rem;
  } div_state_t;

  typedef struct packed {
    logic [DST_W-1:0]   base;
    logic [COL_W-1:0]   row_low;
    logic [COUNT_W-1:0] count;
  } scat_item_t;

  // restoring division, STEP_BITS quotient bits per call
  function automatic div_state_t div_step(div_state_t s, logic [DIVISOR_W-1:0] d);
    div_state_t           t;
    logic [DIVISOR_W:0]   rr;
    t = s;
    for (int k = 0; k < STEP_BITS; k++) begin
      rr    = {t.rem, t.num[GROUP_W-1]};
      t.num = {t.num[GROUP_W-2:0], 1'b0};
      if (rr >= {1'b0, d}) begin
        rr       = rr - {1'b0, d};
        t.num[0] = 1'b1;
      end
      t.rem = rr[DIVISOR_W-1:0];
    end
    return t;
  endfunction

  // face layout offset of element (r, c) in a 32x32 tile
  function automatic logic [SRC_W-1:0] face_offset(logic [COL_W-1:0] r, logic [COL_W-1:0] c);
    return {r[4], c[4], r[3:0], c[3:0]};
  endfunction

endpackage
`default_nettype wire

// ===== design/rtsa_in_if.sv =====
// input channel carrying one reduction group number
`timescale 1ns / 1ps
`default_nettype none
interface rtsa_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] group_index;
  modport source (output valid, output group_index, input ready);
  modport sink (input valid, input group_index, output ready);
endinterface
`default_nettype wire

// ===== design/rtsa_out_if.sv =====
// result channel carrying one source / destination index pair
`timescale 1ns / 1ps
`default_nettype none
interface rtsa_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  source_index;
  logic [31:0] dest_index;
  logic        last;
  modport source (output valid, output source_index, output dest_index, output last,
                  input ready);
  modport sink (input valid, input source_index, input dest_index, input last,
                output ready);
endinterface
`default_nettype wire

// ===== design/rtsa_div.sv =====
// pipelined restoring divider, two quotient bits per stage
`timescale 1ns / 1ps
`default_nettype none
module rtsa_div
  import rtsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire logic [GROUP_W-1:0]   dividend,
  input  wire logic [DIVISOR_W-1:0] divisor,
  input  wire logic [TAG_W-1:0]     tag_in,
  output logic                      out_valid,
  output logic [GROUP_W-1:0]        quotient,
  output logic [DIVISOR_W-1:0]      remainder,
  output logic [TAG_W-1:0]          tag_out
);

  logic       vld [DIV_STAGES];
  div_state_t st  [DIV_STAGES];
  logic [TAG_W-1:0] tg [DIV_STAGES];
  div_state_t start;

  assign start = '{num: dividend, rem: '0};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < DIV_STAGES; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= div_step(start, divisor);
      tg[0] <= tag_in;
      for (int i = 1; i < DIV_STAGES; i++) begin
        st[i] <= div_step(st[i-1], divisor);
        tg[i] <= tg[i-1];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quotient  = st[DIV_STAGES-1].num;
  assign remainder = st[DIV_STAGES-1].rem;
  assign tag_out   = tg[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== design/rtsa_addr.sv =====
// tile number, buffer base and column count, at most one multiply per stage
`timescale 1ns / 1ps
`default_nettype none
module rtsa_addr
  import rtsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire rtsa_cfg_t            cfg,
  input  wire logic                 in_valid,
  input  wire logic [GROUP_W-1:0]   prefix,
  input  wire logic [DIVISOR_W-1:0] row,
  input  wire logic [TAG_W-1:0]     col_tile,
  output logic                      out_valid,
  output scat_item_t                out_item
);

  logic [3:0]         vld;
  logic [DST_W-1:0]   p1, t2, t3, b4;
  logic [10:0]        row_hi1;
  logic [COL_W-1:0]   rl1, rl2, rl3, rl4;
  logic [COUNT_W-1:0] cn1, cn2, cn3, cn4;
  logic [TAG_W-1:0]   ct1, ct2;

  logic [16:0]        col_base, room;
  logic [COUNT_W-1:0] cnt;
  logic [DST_W-1:0]   sum2;

  always_comb begin
    col_base = {col_tile, 5'b0};
    room     = {1'b0, cfg.out_cols} - col_base;
    if ({1'b0, cfg.out_cols} > col_base) begin
      cnt = (room >= 17'(TILE_DIM)) ? COUNT_W'(TILE_DIM) : room[COUNT_W-1:0];
    end else begin
      cnt = '0;
    end
    sum2 = p1 + DST_W'(row_hi1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1      <= DST_W'(prefix) * DST_W'(cfg.tile_rows_per_batch);
      row_hi1 <= row[15:5];
      rl1     <= row[4:0];
      cn1     <= cnt;
      ct1     <= col_tile;

      t2  <= sum2 * DST_W'(cfg.tiles_per_row);
      rl2 <= rl1;
      cn2 <= cn1;
      ct2 <= ct1;

      t3  <= t2 + DST_W'(ct2) - DST_W'(cfg.first_tile);
      rl3 <= rl2;
      cn3 <= cn2;

      b4  <= t3 * DST_W'(cfg.tile_elements);
      rl4 <= rl3;
      cn4 <= cn3;
    end
  end

  assign out_valid = vld[3];
  assign out_item  = '{base: b4, row_low: rl4, count: cn4};

endmodule
`default_nettype wire

// ===== design/rtsa_emit.sv =====
// walks the columns of one group and drives the registered result port
`timescale 1ns / 1ps
`default_nettype none
module rtsa_emit
  import rtsa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       reduce_rows,
  input  wire logic       in_valid,
  input  wire scat_item_t in_item,
  output logic            in_ready,
  rtsa_out_if.source      results
);

  logic               busy;
  scat_item_t         cur;
  logic [COL_W-1:0]   col;
  logic               out_free, fire, at_end, load;
  logic [SRC_W-1:0]   src;

  assign out_free = !results.valid || results.ready;
  assign fire     = busy && out_free;
  assign at_end   = ({1'b0, col} + 6'd1) == cur.count;
  assign in_ready = !busy || (fire && at_end);
  assign load     = in_valid && in_ready;
  assign src      = reduce_rows ? face_offset(col, '0) : face_offset('0, col);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (load) begin
        // groups with no column in range are dropped here
        busy <= (in_item.count != '0);
      end else if (fire && at_end) begin
        busy <= 1'b0;
      end
      if (fire) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= in_item;
      col <= '0;
    end else if (fire) begin
      col <= col + 5'd1;
    end
    if (fire) begin
      results.source_index <= src;
      results.dest_index   <= cur.base + DST_W'(face_offset(cur.row_low, col));
      results.last         <= at_end;
    end
  end

endmodule
`default_nettype wire

// ===== design/reduced_tile_scatter_addresses.sv =====
// top level of the reduced tile scatter address generator
`timescale 1ns / 1ps
`default_nettype none
// Takes one reduction group number per transaction on items and emits, one per cycle
// while results is ready, a source/destination index pair for each column of its column
// tile that lies below out_cols, the last pair flagged. A group has at most 32 columns
// in range; a group with none in range produces nothing. The group number goes through
// two pipelined dividers (12 stages each, two quotient bits a stage) and four
// multiply/add stages; a new group can be accepted every cycle while the column walker
// has room, and the walker sets the sustained rate at one pair per cycle while results
// is ready. Registers are to be written through cfg_we/cfg_index/cfg_data only while
// the block is idle; the user must keep to this, as the block does not enforce it.
module reduced_tile_scatter_addresses
  import rtsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  rtsa_in_if.sink                    items,
  rtsa_out_if.source                 results
);

  rtsa_cfg_t cfg, cfg_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tiles_per_row       <= 12'd1;
      cfg.first_tile          <= '0;
      cfg.out_rows            <= 16'd1;
      cfg.out_cols            <= 16'd1;
      cfg.tile_rows_per_batch <= 12'd1;
      cfg.tile_elements       <= 13'd1024;
      cfg.reduce_rows         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TILES_PER_ROW:       cfg.tiles_per_row       <= cfg_data[11:0];
        REG_FIRST_TILE:          cfg.first_tile          <= cfg_data[23:0];
        REG_OUT_ROWS:            cfg.out_rows            <= cfg_data[15:0];
        REG_OUT_COLS:            cfg.out_cols            <= cfg_data[15:0];
        REG_TILE_ROWS_PER_BATCH: cfg.tile_rows_per_batch <= cfg_data[11:0];
        REG_TILE_ELEMENTS:       cfg.tile_elements       <= cfg_data[12:0];
        REG_REDUCE_ROWS:         cfg.reduce_rows         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a zero divisor acts as one
  always_comb begin
    cfg_eff = cfg;
    if (cfg.tiles_per_row == '0) cfg_eff.tiles_per_row = 12'd1;
    if (cfg.out_rows == '0) cfg_eff.out_rows = 16'd1;
  end

  logic                 adv;
  logic                 d1_valid, d2_valid, a_valid, e_ready;
  logic [GROUP_W-1:0]   row_number, prefix;
  logic [DIVISOR_W-1:0] col_rem, row;
  logic [TAG_W-1:0]     d1_tag, col_tile;
  scat_item_t           a_item;

  assign adv         = !a_valid || e_ready;
  assign items.ready = adv;

  rtsa_div u_div_col (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (items.valid),
    .dividend  (items.group_index),
    .divisor   (DIVISOR_W'(cfg_eff.tiles_per_row)),
    .tag_in    ('0),
    .out_valid (d1_valid),
    .quotient  (row_number),
    .remainder (col_rem),
    .tag_out   (d1_tag)
  );

  rtsa_div u_div_row (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d1_valid),
    .dividend  (row_number),
    .divisor   (cfg_eff.out_rows),
    .tag_in    (col_rem[TAG_W-1:0] | d1_tag),
    .out_valid (d2_valid),
    .quotient  (prefix),
    .remainder (row),
    .tag_out   (col_tile)
  );

  rtsa_addr u_addr (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg_eff),
    .in_valid  (d2_valid),
    .prefix    (prefix),
    .row       (row),
    .col_tile  (col_tile),
    .out_valid (a_valid),
    .out_item  (a_item)
  );

  rtsa_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .reduce_rows (cfg_eff.reduce_rows),
    .in_valid    (a_valid),
    .in_item     (a_item),
    .in_ready    (e_ready),
    .results     (results)
  );

endmodule
`default_nettype wire

// ===== design/rtsa_check.sv =====
// port-level checks for the reduced tile scatter address block
`timescale 1ns / 1ps
`default_nettype none
module rtsa_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [9:0]  source_index,
  input wire logic [31:0] dest_index,
  input wire logic        last
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(source_index)
      && $stable(dest_index) && $stable(last))
    else $error("stalled result changed");

  // source lies either along row 0 or down column 0 of the face layout
  a_src_form: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (source_index[9] == 1'b0 && source_index[7:4] == 4'b0)
      || (source_index[8] == 1'b0 && source_index[3:0] == 4'b0))
    else $error("source index off row 0 and column 0");

  // a valid result and the input handshake carry known values
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(in_ready) && (!out_valid || !$isunknown({source_index, dest_index, last})))
    else $error("unknown value on a handshake or a valid result");

endmodule

bind reduced_tile_scatter_addresses rtsa_check u_rtsa_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (items.valid),
  .in_ready     (items.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .source_index (results.source_index),
  .dest_index   (results.dest_index),
  .last         (results.last)
);
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the reduced tile scatter address generator
`timescale 1ns / 1ps
module testbench;
  import rtsa_pkg::*;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [DST_W-1:0] dst;
    logic             last;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rtsa_in_if items ();
  rtsa_out_if results ();

  reduced_tile_scatter_addresses i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .items(items), .results(results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the block's registers
  logic [11:0] tpr_q = 12'd1;
  logic [23:0] first_q = '0;
  logic [15:0] rows_q = 16'd1;
  logic [15:0] cols_q = 16'd1;
  logic [11:0] trpb_q = 12'd1;
  logic [12:0] elems_q = 13'd1024;
  logic        redrows_q = 1'b0;

  logic [23:0] group_queue[$];
  pair_t       pair_queue[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  bit          failed = 0;

  function automatic logic [9:0] face_pos(logic [4:0] r, logic [4:0] c);
    logic [9:0] v;
    v = ({9'd0, r[4]} * 10'd2 + {9'd0, c[4]}) * 10'd256 + {6'd0, r[3:0]} * 10'd16
        + {6'd0, c[3:0]};
    return v;
  endfunction

  // expected index pairs for one accepted group
  task automatic predict_pairs(logic [23:0] g);
    logic [31:0] tpr, rows, col_tile, row_number, prefix, row, col_base, tile, base, count;
    pair_t p;
    tpr = (tpr_q == 0) ? 32'd1 : {20'd0, tpr_q};
    rows = (rows_q == 0) ? 32'd1 : {16'd0, rows_q};
    col_tile = g % tpr;
    row_number = g / tpr;
    prefix = row_number / rows;
    row = row_number % rows;
    col_base = col_tile * 32;
    tile = (prefix * trpb_q + row / 32) * tpr + col_tile;
    base = (tile - {8'd0, first_q}) * {19'd0, elems_q};
    count = 0;
    if ({16'd0, cols_q} > col_base) begin
      count = {16'd0, cols_q} - col_base;
      if (count > 32) count = 32;
    end
    for (int c = 0; c < count; c++) begin
      p.src = redrows_q ? face_pos(c[4:0], 5'd0) : face_pos(5'd0, c[4:0]);
      p.dst = base + {22'd0, face_pos(row[4:0], c[4:0])};
      p.last = (c + 1 == count);
      pair_queue.push_back(p);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      items.valid <= 1'b0;
      items.group_index <= '0;
    end else if (!items.valid || items.ready) begin
      if (items.valid) predict_pairs(items.group_index);
      if (group_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        items.valid <= 1'b1;
        items.group_index <= group_queue.pop_front();
      end else begin
        items.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    pair_t exp_p;
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        if (pair_queue.size() == 0) begin
          $display("%0t unexpected pair src=%0d dst=%h last=%0b", $time,
                   results.source_index, results.dest_index, results.last);
          failed = 1;
        end else begin
          exp_p = pair_queue.pop_front();
          if (exp_p.src !== results.source_index || exp_p.dst !== results.dest_index ||
              exp_p.last !== results.last) begin
            $display("%0t mismatch expected src=%0d dst=%h last=%0b actual src=%0d dst=%h last=%0b",
                     $time, exp_p.src, exp_p.dst, exp_p.last, results.source_index,
                     results.dest_index, results.last);
            failed = 1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        results.ready <= 1'b0;
      end else begin
        results.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(reg_index_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    case (idx)
      REG_TILES_PER_ROW:       tpr_q <= val[11:0];
      REG_FIRST_TILE:          first_q <= val[23:0];
      REG_OUT_ROWS:            rows_q <= val[15:0];
      REG_OUT_COLS:            cols_q <= val[15:0];
      REG_TILE_ROWS_PER_BATCH: trpb_q <= val[11:0];
      REG_TILE_ELEMENTS:       elems_q <= val[12:0];
      REG_REDUCE_ROWS:         redrows_q <= val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(int tpr, int ft, int orr, int oc, int trpb, int te, int rr);
    write_reg(REG_TILES_PER_ROW, tpr);
    write_reg(REG_FIRST_TILE, ft);
    write_reg(REG_OUT_ROWS, orr);
    write_reg(REG_OUT_COLS, oc);
    write_reg(REG_TILE_ROWS_PER_BATCH, trpb);
    write_reg(REG_TILE_ELEMENTS, te);
    write_reg(REG_REDUCE_ROWS, rr);
  endtask

  // wait for the block to drain; groups with no columns can still be in flight
  task automatic drain();
    wait (group_queue.size() == 0 && !items.valid && pair_queue.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: group_queue.push_back(24'($urandom_range(63)));
        1: group_queue.push_back(24'($urandom_range(4095)));
        default: group_queue.push_back(24'($urandom));
      endcase
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, extremes of group number
    group_queue.push_back(24'd0);
    group_queue.push_back(24'hffffff);
    group_queue.push_back(24'h555555);
    group_queue.push_back(24'haaaaaa);
    drain();
    // full and partial tiles, column mode, wrap below first tile
    set_all(3, 24'hffffff, 70, 80, 5, 4096, 1);
    for (int i = 0; i < 10; i++) group_queue.push_back(24'(i));
    group_queue.push_back(24'hffffff);
    drain();
    // zero divisors, bad register index ignored
    set_all(0, 0, 0, 40, 2048, 1024, 0);
    write_reg(reg_index_t'(3'd7), 24'h123456);
    for (int i = 0; i < 6; i++) group_queue.push_back(24'(i * 1000));
    drain();
    set_all(2048, 16777215, 65535, 65535, 0, 8191, 1);
    group_queue.push_back(24'd2047);
    group_queue.push_back(24'hfffffe);
    group_queue.push_back(24'd12345);
    drain();

    // random phases
    set_all(4, 0, 33, 100, 3, 1024, 0);
    random_phase(70, 0, 0);
    set_all($urandom_range(1, 2048), $urandom & 24'hffffff, $urandom_range(1, 65535),
            $urandom_range(1, 65535), $urandom_range(1, 2048), $urandom_range(1024, 4096), 1);
    random_phase(70, 67, 0);
    set_all($urandom_range(1, 8), $urandom_range(0, 50), $urandom_range(1, 100),
            $urandom_range(1, 300), $urandom_range(1, 8), $urandom_range(1024, 4096), 0);
    random_phase(70, 0, 67);
    set_all($urandom_range(1, 16), 0, $urandom_range(1, 64), $urandom_range(1, 600),
            $urandom_range(1, 4), 4096, 1);
    random_phase(70, 35, 35);

    // long receiver hold-off while the sender keeps offering groups
    set_all(2, 0, 40, 64, 2, 1024, 0);
    hold_cycles = 400;
    random_phase(76, 0, 0);

    repeat (60) @(posedge clk);
    if (pair_queue.size() != 0) begin
      $display("%0t %0d expected pairs never arrived", $time, pair_queue.size());
      failed = 1;
    end
    if (!failed)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
